// ===== sv/sti_pkg.sv =====
// ============================================================================
// sti_pkg
// Shared widths and helpers for the segment/triangle intersection core.
// ============================================================================
package sti_pkg;
    localparam int COORD_BITS  = 21;
    localparam int FIELD_BITS  = 63;
    localparam int TOL_BITS    = 32;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS   = 2 * DIFF_BITS;
    localparam int NRM_BITS    = PROD_BITS + 1;
    localparam int DOTP_BITS   = NRM_BITS + DIFF_BITS;
    localparam int DOT_BITS    = DOTP_BITS + 2;
    localparam int PIPE_STAGES = 6;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [NRM_BITS-1:0]   nrm_t;
    typedef logic signed [DOTP_BITS-1:0]  dotp_t;
    typedef logic signed [DOT_BITS-1:0]   dot_t;

    typedef struct packed {
        diff_t [2:0] ab;
        diff_t [2:0] ac;
        diff_t [2:0] ap;
        diff_t [2:0] aq;
        diff_t [2:0] dir;
    } diffs_t;

    typedef struct packed {
        nrm_t [2:0] n;
        nrm_t [2:0] m2;
        nrm_t [2:0] m3;
        diff_t [2:0] ap;
        diff_t [2:0] aq;
        diff_t [2:0] dir;
    } crosses_t;

    typedef struct packed {
        dotp_t [2:0] dp;
        dotp_t [2:0] dq;
        dotp_t [2:0] dn;
        dotp_t [2:0] d2;
        dotp_t [2:0] d3;
    } prods_t;

    typedef struct packed {
        dot_t dp;
        dot_t dq;
        dot_t den;
        dot_t det2;
        dot_t det3;
    } dots_t;

    function automatic coord_t get_coord(input logic [FIELD_BITS-1:0] f, input int i);
        get_coord = coord_t'(f[i*COORD_BITS +: COORD_BITS]);
    endfunction
endpackage

// ===== sv/segment_triangle_intersect_core.sv =====
// ============================================================================
// segment_triangle_intersect_core
// Exact fixed-point segment/triangle hit test, one beat per cycle unless stalled.
// ============================================================================
// Accepts one beat per cycle when not stalled and returns its hit bit through a
// six-stage pipeline (differences, cross products, dot partial products, dot
// sums, compares, output); the pipe stalls only on an untaken output beat.
// The user writes plane_tolerance only while idle; the core does not enforce it.
module segment_triangle_intersect_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sti_pkg::TOL_BITS-1:0]   cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [sti_pkg::FIELD_BITS-1:0] s_vertex_a,
    input  logic [sti_pkg::FIELD_BITS-1:0] s_vertex_b,
    input  logic [sti_pkg::FIELD_BITS-1:0] s_vertex_c,
    input  logic [sti_pkg::FIELD_BITS-1:0] s_seg_start,
    input  logic [sti_pkg::FIELD_BITS-1:0] s_seg_end,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_hit
);
    import sti_pkg::*;

    logic [TOL_BITS-1:0] tol_reg;
    logic en;
    logic [PIPE_STAGES-1:0] vld;
    diffs_t   d_next, d_reg;
    crosses_t c_next, c_reg;
    prods_t   p_next, p_reg;
    dots_t    sum_next, sum_reg;
    logic     h_next, h_reg;
    logic     hit_reg;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
        end else if (cfg_wr_en) begin
            tol_reg <= cfg_wr_data;
        end
    end

    sti_stage u_valid (.aclk, .aresetn, .en, .in_valid(s_valid), .valid(vld));

    always_ff @(posedge aclk) begin
        if (en && s_valid) begin
            d_reg <= d_next;
        end
        if (en && vld[0]) begin
            c_reg <= c_next;
        end
        if (en && vld[1]) begin
            p_reg <= p_next;
        end
        if (en && vld[2]) begin
            sum_reg <= sum_next;
        end
        if (en && vld[3]) begin
            h_reg <= h_next;
        end
        if (en && vld[4]) begin
            hit_reg <= h_reg;
        end
    end

    assign m_valid = vld[PIPE_STAGES-1];
    assign m_hit   = hit_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_next.ab[i]  = diff_t'(get_coord(s_vertex_b, i)) - diff_t'(get_coord(s_vertex_a, i));
            d_next.ac[i]  = diff_t'(get_coord(s_vertex_c, i)) - diff_t'(get_coord(s_vertex_a, i));
            d_next.ap[i]  = diff_t'(get_coord(s_seg_start, i)) - diff_t'(get_coord(s_vertex_a, i));
            d_next.aq[i]  = diff_t'(get_coord(s_seg_end, i)) - diff_t'(get_coord(s_vertex_a, i));
            d_next.dir[i] = diff_t'(get_coord(s_seg_end, i)) - diff_t'(get_coord(s_seg_start, i));
        end
    end

    function automatic nrm_t xp(input diff_t a1, input diff_t b2, input diff_t a2,
                                input diff_t b1);
        xp = nrm_t'(a1) * nrm_t'(b2) - nrm_t'(a2) * nrm_t'(b1);
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_next.n[i]  = xp(d_reg.ab[(i+1)%3], d_reg.ac[(i+2)%3], d_reg.ab[(i+2)%3],
                              d_reg.ac[(i+1)%3]);
            c_next.m2[i] = xp(d_reg.ap[(i+1)%3], d_reg.ac[(i+2)%3], d_reg.ap[(i+2)%3],
                              d_reg.ac[(i+1)%3]);
            c_next.m3[i] = xp(d_reg.ab[(i+1)%3], d_reg.ap[(i+2)%3], d_reg.ab[(i+2)%3],
                              d_reg.ap[(i+1)%3]);
        end
        c_next.ap  = d_reg.ap;
        c_next.aq  = d_reg.aq;
        c_next.dir = d_reg.dir;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p_next.dp[i] = dotp_t'(c_reg.n[i]) * dotp_t'(c_reg.ap[i]);
            p_next.dq[i] = dotp_t'(c_reg.n[i]) * dotp_t'(c_reg.aq[i]);
            p_next.dn[i] = dotp_t'(c_reg.n[i]) * dotp_t'(c_reg.dir[i]);
            p_next.d2[i] = dotp_t'(c_reg.m2[i]) * dotp_t'(c_reg.dir[i]);
            p_next.d3[i] = dotp_t'(c_reg.m3[i]) * dotp_t'(c_reg.dir[i]);
        end
    end

    function automatic dot_t sum3(input dotp_t [2:0] p);
        sum3 = dot_t'(p[0]) + dot_t'(p[1]) + dot_t'(p[2]);
    endfunction

    always_comb begin
        sum_next.dp   = sum3(p_reg.dp);
        sum_next.dq   = sum3(p_reg.dq);
        sum_next.den  = sum3(p_reg.dn);
        sum_next.det2 = -sum3(p_reg.d2);
        sum_next.det3 = -sum3(p_reg.d3);
    end

    always_comb begin
        dot_t tol, ntol, aden, num, det, d2, d3;
        logic same_side, parallel, t_bad, bary_bad;
        tol  = dot_t'({1'b0, tol_reg});
        ntol = -tol;
        same_side = (sum_reg.dp < ntol && sum_reg.dq < ntol) ||
                    (sum_reg.dp > tol && sum_reg.dq > tol);
        aden = sum_reg.den[DOT_BITS-1] ? -sum_reg.den : sum_reg.den;
        parallel = aden <= tol;
        num = sum_reg.den[DOT_BITS-1] ? sum_reg.dp : -sum_reg.dp;
        t_bad = num[DOT_BITS-1] || num > aden;
        det = -sum_reg.den;
        d2 = sum_reg.det2;
        d3 = sum_reg.det3;
        if (det[DOT_BITS-1]) begin
            det = -det;
            d2  = -d2;
            d3  = -d3;
        end
        bary_bad = d2[DOT_BITS-1] || d3[DOT_BITS-1] || (d2 + d3) > det;
        h_next = !(same_side || parallel || t_bad || bary_bad);
    end
endmodule

// ===== sv/sti_stage.sv =====
// ============================================================================
// sti_stage
// Valid-bit chain for the pipeline stages, with stall handling.
// ============================================================================
module sti_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    output logic [sti_pkg::PIPE_STAGES-1:0] valid
);
    import sti_pkg::*;

    logic [PIPE_STAGES-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[PIPE_STAGES-2:0], in_valid};
        end
    end

    assign valid = valid_reg;
endmodule

// ===== test/segment_triangle_intersect_core_test.sv =====
// ============================================================================
// segment_triangle_intersect_core_test
// Self-checking bench for the segment/triangle hit core: a directed table,
// then random triangles with segments aimed at them, checked beat by beat
// against an exact integer hit predictor, over several tolerance settings.
// ============================================================================
module segment_triangle_intersect_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sti_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int PIPE_DEPTH = 6;

    typedef logic [FIELD_BITS-1:0] field_t;
    typedef logic signed [127:0] big_t;
    typedef logic signed [63:0] sv_t;

    // expected column: 0/1 typed in, HIT_PREDICT = use predictor
    localparam int HIT_PREDICT = 2;

    typedef struct {
        field_t a, b, c, p, q;
        int     want;
    } vec_row_t;

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  cfg_wr_en = 0;
    logic [TOL_BITS-1:0]   cfg_wr_data = '0;
    logic                  s_valid = 0;
    logic                  s_ready;
    field_t                s_vertex_a = '0, s_vertex_b = '0, s_vertex_c = '0;
    field_t                s_seg_start = '0, s_seg_end = '0;
    logic                  m_valid;
    logic                  m_ready = 0;
    logic                  m_hit;

    segment_triangle_intersect_core dut (.*);

    always #2 aclk = ~aclk;

    logic [TOL_BITS-1:0] tolerance = '0;
    bit   hits_expected[$];
    int   mismatches = 0;
    int   send_idle_pct = 0, recv_idle_pct = 0;
    bit   sending = 0;

    function automatic sv_t coord_of(field_t f, int i);
        logic signed [CB-1:0] c;
        c = f[i*CB +: CB];
        return sv_t'(c);
    endfunction

    function automatic field_t pack3(sv_t x, sv_t y, sv_t z);
        field_t f;
        f = '0;
        f[0 +: CB] = x[CB-1:0];
        f[CB +: CB] = y[CB-1:0];
        f[2*CB +: CB] = z[CB-1:0];
        return f;
    endfunction

    function automatic void cross3(input sv_t u[3], input sv_t v[3], output sv_t r[3]);
        r[0] = u[1]*v[2] - u[2]*v[1];
        r[1] = u[2]*v[0] - u[0]*v[2];
        r[2] = u[0]*v[1] - u[1]*v[0];
    endfunction

    function automatic big_t dot3(sv_t u[3], sv_t v[3]);
        big_t s;
        s = 0;
        for (int i = 0; i < 3; i++) s += big_t'(u[i]) * big_t'(v[i]);
        return s;
    endfunction

    function automatic bit segment_hit(field_t fa, field_t fb, field_t fc,
                                       field_t fp, field_t fq, logic [TOL_BITS-1:0] tl);
        sv_t ab[3], ac[3], ap[3], aq[3], dir[3], n[3], m2[3], m3[3];
        big_t tol, dp, dq, den, num, det, det2, det3;
        tol = big_t'({1'b0, tl});
        for (int i = 0; i < 3; i++) begin
            ab[i] = coord_of(fb, i) - coord_of(fa, i);
            ac[i] = coord_of(fc, i) - coord_of(fa, i);
            ap[i] = coord_of(fp, i) - coord_of(fa, i);
            aq[i] = coord_of(fq, i) - coord_of(fa, i);
            dir[i] = coord_of(fq, i) - coord_of(fp, i);
        end
        cross3(ab, ac, n);
        dp = dot3(n, ap);
        dq = dot3(n, aq);
        if ((dp < -tol && dq < -tol) || (dp > tol && dq > tol)) return 0;
        den = dot3(n, dir);
        if ((den < 0 ? -den : den) <= tol) return 0;
        num = -dp;
        det = -den;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        if (num < 0 || num > den) return 0;
        cross3(ap, ac, m2);
        cross3(ab, ap, m3);
        det2 = -dot3(dir, m2);
        det3 = -dot3(dir, m3);
        if (det < 0) begin
            det = -det;
            det2 = -det2;
            det3 = -det3;
        end
        if (det2 < 0 || det3 < 0) return 0;
        if (det2 + det3 > det) return 0;
        return 1;
    endfunction

    task automatic send_beat(field_t a, field_t b, field_t c, field_t p, field_t q, int want);
        bit h;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        h = segment_hit(a, b, c, p, q, tolerance);
        if (want != HIT_PREDICT && h != bit'(want)) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row mismatch: expected %0d predictor %0d", want, h);
        end
        s_vertex_a <= a; s_vertex_b <= b; s_vertex_c <= c;
        s_seg_start <= p; s_seg_end <= q;
        s_valid <= 1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        hits_expected.push_back(want == HIT_PREDICT ? h : bit'(want));
        @(negedge aclk);
    endtask

    always @(negedge aclk)
        m_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (hits_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat: hit=%0b", m_hit);
            end else begin
                bit e;
                e = hits_expected.pop_front();
                if (m_hit !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("hit mismatch: expected %0b actual %0b", e, m_hit);
                end
            end
        end
    end

    task automatic drain();
        int guard;
        guard = 0;
        s_valid <= 0;
        while (hits_expected.size() != 0 && guard < 100000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (PIPE_DEPTH + 4) @(negedge aclk);
    endtask

    task automatic set_tolerance(logic [TOL_BITS-1:0] v);
        cfg_wr_data <= v;
        cfg_wr_en <= 1;
        @(negedge aclk);
        cfg_wr_en <= 0;
        tolerance = v;
    endtask

    function automatic sv_t rnd_coord(int span);
        if (span >= (1 << (CB-1))) return coord_of(field_t'($urandom_range((1<<CB)-1)), 0);
        return sv_t'($urandom_range(2*span)) - span;
    endfunction

    function automatic field_t rnd_point(int span);
        field_t f;
        f = pack3(rnd_coord(span), rnd_coord(span), rnd_coord(span));
        if ($urandom_range(3) == 0) f[FIELD_BITS-1] = $urandom_range(1);
        return f;
    endfunction

    // random triangle with a segment mostly aimed through or near its plane
    task automatic random_beat();
        field_t a, b, c, p, q;
        int span, k;
        sv_t t[3];
        span = ($urandom_range(9) == 0) ? (1 << (CB-1)) : (1 << $urandom_range(4, 18));
        a = rnd_point(span); b = rnd_point(span); c = rnd_point(span);
        k = $urandom_range(9);
        if (k < 7) begin
            // pick a point in or near the triangle; mostly straddle it by a random offset
            int wa, wb;
            sv_t off[3], px[3], qx[3];
            wa = $urandom_range(256); wb = $urandom_range(256 - wa);
            if (k == 0) wa = 200 + $urandom_range(100);
            for (int i = 0; i < 3; i++) begin
                t[i] = coord_of(a, i) + ((coord_of(b, i) - coord_of(a, i)) * wa
                       + (coord_of(c, i) - coord_of(a, i)) * wb) / 256;
                off[i] = rnd_coord(span / 2 + 1);
                px[i] = t[i] + off[i];
                qx[i] = t[i] - off[i] * $urandom_range(1, 3);
                if (k == 1) qx[i] = t[i] + off[i] / 2;
            end
            p = pack3(px[0], px[1], px[2]);
            q = pack3(qx[0], qx[1], qx[2]);
        end else if (k == 7) begin
            p = a;
            q = ($urandom_range(1)) ? b : c;
        end else begin
            p = rnd_point(span);
            q = rnd_point(span);
        end
        send_beat(a, b, c, p, q, HIT_PREDICT);
    endtask

    vec_row_t directed_rows[$];

    task automatic load_rows();
        sv_t M, N, U;
        field_t A, B, C;
        M = (1 <<< (CB-1)) - 1;
        N = -(1 <<< (CB-1));
        U = 65536;
        A = pack3(0, 0, 0); B = pack3(U, 0, 0); C = pack3(0, U, 0);
        directed_rows = '{
            '{A, B, C, pack3(U/4, U/4, U), pack3(U/4, U/4, -U), 1},
            '{A, B, C, pack3(U/4, U/4, U), pack3(U/4, U/4, U/2), 0},
            '{A, B, C, pack3(U, U, U), pack3(U, U, -U), 0},
            '{A, B, C, pack3(U/4, U/4, 0), pack3(U, U/4, 0), 0},
            '{A, B, C, pack3(U/4, U/4, U), pack3(U/4, U/4, U), 0},
            '{A, A, C, pack3(0, 1, U), pack3(0, 1, -U), 0},
            '{A, B, C, pack3(0, 0, U), pack3(0, 0, -U), 1},
            '{A, B, C, pack3(U/2, U/2, U), pack3(U/2, U/2, -U), 1},
            '{A, B, C, pack3(U/4, U/4, 0), pack3(U/4, U/4, -U), 1},
            '{A, B, C, pack3(U/4, U/4, U), pack3(U/4, U/4, 0), 1},
            '{A | (field_t'(1) << 63-1), B, C, pack3(U/4, U/4, U),
              pack3(U/4, U/4, -U) | (field_t'(1) << 62), HIT_PREDICT},
            '{pack3(N, N, N), pack3(M, N, N), pack3(N, M, N), pack3(N, N, M),
              pack3(M, M, N), HIT_PREDICT},
            '{pack3(N, N, 0), pack3(M, N, 0), pack3(N, M, 0), pack3(0, 0, M),
              pack3(0, 0, N), HIT_PREDICT},
            '{pack3(M, M, M), pack3(N, M, M), pack3(M, N, M), pack3(M, M, N),
              pack3(N, N, M), HIT_PREDICT},
            '{'1 >> 1, '0, '1 >> 1, '0, '1 >> 1, HIT_PREDICT},
            '{A, B, C, pack3(-1, -1, U), pack3(-1, -1, -U), 0}
        };
    endtask

    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        load_rows();
        repeat (6) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        foreach (directed_rows[i])
            send_beat(directed_rows[i].a, directed_rows[i].b, directed_rows[i].c,
                      directed_rows[i].p, directed_rows[i].q, directed_rows[i].want);
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_tolerance('1);
                1: set_tolerance($urandom_range(1 << 20));
                2: set_tolerance(32'h0000_0001);
                3: set_tolerance($urandom());
                4: set_tolerance(32'h8000_0000);
                default: set_tolerance('0);
            endcase
            send_idle_pct = (ph < 2) ? 28 : (ph < 4) ? 48 : 0;
            recv_idle_pct = (ph < 2) ? 48 : (ph < 4) ? 28 : 0;
            repeat (160) random_beat();
            drain();
        end
        if (hits_expected.size() != 0) mismatches += hits_expected.size();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
